>>> sv/hrp_pkg.sv
// Shared types and constants for the HTTP request head parser.
// Used by the parser front end, the result queue and the result sequencer.
package hrp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_URI   = 2'd1;
  localparam logic [1:0] ROLE_NAME  = 2'd2;
  localparam logic [1:0] ROLE_VALUE = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_METHOD   = 3'd1;
  localparam logic [2:0] ERR_URI      = 3'd2;
  localparam logic [2:0] ERR_CONSTANT = 3'd3;
  localparam logic [2:0] ERR_VERSION  = 3'd4;
  localparam logic [2:0] ERR_LF       = 3'd5;
  localparam logic [2:0] ERR_HEADER   = 3'd6;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // One parsed input word: the main result, and a flag for a leading
  // collapsed space result that precedes it.
  typedef struct packed {
    logic       pair;
    logic [7:0] out_byte;
    logic [1:0] role;
    logic       field_start;
    logic       method_done;
    logic       uri_done;
    logic       version_done;
    logic       header_done;
    logic       request_done;
    logic [2:0] error_code;
    logic [3:0] version_major;
    logic [3:0] version_minor;
  } hrp_rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_path_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || is_digit(c) ||
           c == CH_UNDER || c == CH_SLASH || c == CH_DOT;
  endfunction

endpackage

>>> sv/hrp_front.sv
// Parser front end: accepts request bytes, runs the parse state machine and
// emits one record per byte. Depends on hrp_pkg.
module hrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_ok,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output hrp_pkg::hrp_rec_t rec
);
  import hrp_pkg::*;

  localparam logic [4:0] ST_START    = 5'd0;
  localparam logic [4:0] ST_METHOD   = 5'd1;
  localparam logic [4:0] ST_SP_URI   = 5'd2;
  localparam logic [4:0] ST_PATH     = 5'd3;
  localparam logic [4:0] ST_HSTART   = 5'd4;
  localparam logic [4:0] ST_H        = 5'd5;
  localparam logic [4:0] ST_HT       = 5'd6;
  localparam logic [4:0] ST_HTT      = 5'd7;
  localparam logic [4:0] ST_HTTP     = 5'd8;
  localparam logic [4:0] ST_MAJOR    = 5'd9;
  localparam logic [4:0] ST_DOT      = 5'd10;
  localparam logic [4:0] ST_MINOR    = 5'd11;
  localparam logic [4:0] ST_LINE_END = 5'd12;
  localparam logic [4:0] ST_LINE_LF  = 5'd13;
  localparam logic [4:0] ST_FSTART   = 5'd14;
  localparam logic [4:0] ST_FIELD    = 5'd15;
  localparam logic [4:0] ST_VSTART   = 5'd16;
  localparam logic [4:0] ST_SP_VAL   = 5'd17;
  localparam logic [4:0] ST_VALUE    = 5'd18;
  localparam logic [4:0] ST_SP_AFTER = 5'd19;
  localparam logic [4:0] ST_HDR_LF   = 5'd20;
  localparam logic [4:0] ST_END_LF   = 5'd21;

  logic [4:0] state, state_cur, state_next;
  logic [1:0] method_pos, pos_cur, method_pos_next;
  logic [3:0] major_digit, major_cur, major_digit_next;
  logic [3:0] minor_digit, minor_cur, minor_digit_next;
  logic [2:0] sticky_error, error_cur, sticky_error_next;
  logic [2:0] err_new;
  logic [7:0] get_char;
  logic [7:0] digit_value;

  assign state_cur   = restart ? ST_START : state;
  assign pos_cur     = restart ? 2'd0 : method_pos;
  assign major_cur   = restart ? 4'd0 : major_digit;
  assign minor_cur   = restart ? 4'd0 : minor_digit;
  assign error_cur   = restart ? ERR_NONE : sticky_error;
  assign digit_value = data_byte - CH_0;

  always_comb begin
    case (pos_cur)
      2'd0:    get_char = CH_G;
      2'd1:    get_char = CH_E;
      default: get_char = CH_T;
    endcase
  end

  always_comb begin
    state_next       = state_cur;
    method_pos_next  = pos_cur;
    major_digit_next = major_cur;
    minor_digit_next = minor_cur;
    err_new          = ERR_NONE;
    rec              = '0;
    if (error_cur == ERR_NONE) begin
      case (state_cur)
        ST_METHOD: begin
          if (pos_cur != 2'd3 && data_byte == get_char) begin
            method_pos_next = pos_cur + 2'd1;
          end else if (pos_cur == 2'd3 && data_byte == CH_SP) begin
            rec.method_done = 1'b1;
            state_next = ST_SP_URI;
          end else begin
            err_new = ERR_METHOD;
          end
        end
        ST_SP_URI: begin
          if (data_byte == CH_SLASH) begin
            rec.out_byte = data_byte;
            rec.role = ROLE_URI;
            rec.field_start = 1'b1;
            state_next = ST_PATH;
          end else if (data_byte != CH_SP) begin
            err_new = ERR_URI;
          end
        end
        ST_PATH: begin
          if (data_byte == CH_SP) begin
            rec.uri_done = 1'b1;
            state_next = ST_HSTART;
          end else if (is_path_char(data_byte)) begin
            rec.out_byte = data_byte;
            rec.role = ROLE_URI;
          end else begin
            err_new = ERR_URI;
          end
        end
        ST_HSTART: begin
          if (data_byte == CH_H) state_next = ST_H;
          else if (data_byte != CH_SP) err_new = ERR_CONSTANT;
        end
        ST_H: begin
          if (data_byte == CH_T) state_next = ST_HT;
          else err_new = ERR_CONSTANT;
        end
        ST_HT: begin
          if (data_byte == CH_T) state_next = ST_HTT;
          else err_new = ERR_CONSTANT;
        end
        ST_HTT: begin
          if (data_byte == CH_P) state_next = ST_HTTP;
          else err_new = ERR_CONSTANT;
        end
        ST_HTTP: begin
          if (data_byte == CH_SLASH) state_next = ST_MAJOR;
          else err_new = ERR_CONSTANT;
        end
        ST_MAJOR: begin
          if (is_digit(data_byte)) begin
            major_digit_next = digit_value[3:0];
            state_next = ST_DOT;
          end else begin
            err_new = ERR_VERSION;
          end
        end
        ST_DOT: begin
          if (data_byte == CH_DOT) state_next = ST_MINOR;
          else err_new = ERR_VERSION;
        end
        ST_MINOR: begin
          if (is_digit(data_byte)) begin
            minor_digit_next = digit_value[3:0];
            rec.version_done = 1'b1;
            state_next = ST_LINE_END;
          end else begin
            err_new = ERR_VERSION;
          end
        end
        ST_LINE_END: begin
          if (data_byte == CH_CR) state_next = ST_LINE_LF;
          else if (data_byte == CH_LF) state_next = ST_FSTART;
          else err_new = ERR_VERSION;
        end
        ST_LINE_LF: begin
          if (data_byte == CH_LF) state_next = ST_FSTART;
          else err_new = ERR_LF;
        end
        ST_FSTART: begin
          if (data_byte == CH_CR) begin
            state_next = ST_END_LF;
          end else if (data_byte == CH_LF) begin
            rec.request_done = 1'b1;
            state_next = ST_START;
          end else begin
            rec.out_byte = data_byte;
            rec.role = ROLE_NAME;
            rec.field_start = 1'b1;
            state_next = ST_FIELD;
          end
        end
        ST_FIELD: begin
          if (data_byte == CH_COLON) begin
            state_next = ST_VSTART;
          end else if (data_byte == CH_CR) begin
            state_next = ST_HDR_LF;
          end else begin
            rec.out_byte = data_byte;
            rec.role = ROLE_NAME;
          end
        end
        ST_VSTART: begin
          if (data_byte == CH_SP) state_next = ST_SP_VAL;
          else err_new = ERR_HEADER;
        end
        ST_SP_VAL: begin
          if (data_byte == CH_CR) begin
            state_next = ST_HDR_LF;
          end else if (data_byte != CH_SP) begin
            rec.out_byte = data_byte;
            rec.role = ROLE_VALUE;
            rec.field_start = 1'b1;
            state_next = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (data_byte == CH_CR) begin
            state_next = ST_HDR_LF;
          end else if (data_byte == CH_SP) begin
            state_next = ST_SP_AFTER;
          end else begin
            rec.out_byte = data_byte;
            rec.role = ROLE_VALUE;
          end
        end
        ST_SP_AFTER: begin
          if (data_byte == CH_CR) begin
            state_next = ST_HDR_LF;
          end else if (data_byte != CH_SP) begin
            rec.pair = 1'b1;
            rec.out_byte = data_byte;
            rec.role = ROLE_VALUE;
            state_next = ST_VALUE;
          end
        end
        ST_HDR_LF: begin
          if (data_byte == CH_LF) begin
            rec.header_done = 1'b1;
            state_next = ST_FSTART;
          end else begin
            err_new = ERR_LF;
          end
        end
        ST_END_LF: begin
          if (data_byte == CH_LF) begin
            rec.request_done = 1'b1;
            state_next = ST_START;
          end else begin
            err_new = ERR_LF;
          end
        end
        default: begin
          if (data_byte == CH_G) begin
            method_pos_next = 2'd1;
            state_next = ST_METHOD;
          end else if (data_byte != CH_CR && data_byte != CH_LF) begin
            err_new = ERR_METHOD;
          end
        end
      endcase
    end
    sticky_error_next = (err_new != ERR_NONE) ? err_new : error_cur;
    rec.error_code    = sticky_error_next;
    rec.version_major = major_digit_next;
    rec.version_minor = minor_digit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      method_pos   <= 2'd0;
      major_digit  <= 4'd0;
      minor_digit  <= 4'd0;
      sticky_error <= ERR_NONE;
    end else if (take && push_ok) begin
      state        <= state_next;
      method_pos   <= method_pos_next;
      major_digit  <= major_digit_next;
      minor_digit  <= minor_digit_next;
      sticky_error <= sticky_error_next;
    end
  end

endmodule

>>> sv/hrp_queue.sv
// Short queue of parsed records between the parser and the result sequencer.
// Depends on hrp_pkg for the record type.
module hrp_queue #(
  parameter int DEPTH = hrp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hrp_pkg::hrp_rec_t push_rec,
  input  logic              pop,
  output hrp_pkg::hrp_rec_t head,
  output logic              full,
  output logic              empty
);
  import hrp_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hrp_rec_t      entries [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/hrp_back.sv
// Result sequencer: expands queued records into one or two results and holds
// them in the output register. Depends on hrp_pkg.
module hrp_back (
  input  logic              clk,
  input  logic              rst,
  input  hrp_pkg::hrp_rec_t head,
  input  logic              empty,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        role,
  output logic              field_start,
  output logic              method_done,
  output logic              uri_done,
  output logic              version_done,
  output logic              header_done,
  output logic              request_done,
  output logic [2:0]        error_code,
  output logic [3:0]        version_major,
  output logic [3:0]        version_minor,
  output logic              last
);
  import hrp_pkg::*;

  logic load;
  logic extra;
  logic space_sent;

  assign load  = !empty && (!result_valid || !result_stall);
  assign extra = head.pair && !space_sent;
  assign pop   = load && !extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      space_sent   <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        space_sent   <= extra;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      version_major <= head.version_major;
      version_minor <= head.version_minor;
      if (extra) begin
        out_byte     <= CH_SP;
        role         <= ROLE_VALUE;
        field_start  <= 1'b0;
        method_done  <= 1'b0;
        uri_done     <= 1'b0;
        version_done <= 1'b0;
        header_done  <= 1'b0;
        request_done <= 1'b0;
        error_code   <= ERR_NONE;
        last         <= 1'b0;
      end else begin
        out_byte     <= head.out_byte;
        role         <= head.role;
        field_start  <= head.field_start;
        method_done  <= head.method_done;
        uri_done     <= head.uri_done;
        version_done <= head.version_done;
        header_done  <= head.header_done;
        request_done <= head.request_done;
        error_code   <= head.error_code;
        last         <= 1'b1;
      end
    end
  end

endmodule

>>> sv/http_request_head_parser_core.sv
// Top level of the HTTP request head parser: parser front end, record queue
// and result sequencer. Depends on hrp_pkg, hrp_front, hrp_queue, hrp_back.
//
//   Channel  Handshake                  Payload
//   bytes    byte_valid / byte_stall    data_byte, restart
//   results  result_valid / result_stall out_byte, role, field_start, flags,
//                                        error_code, version digits, last
//
// A byte is parsed in the cycle it is accepted; its record is written to the
// queue, then loaded into the output register.
// Bytes are taken one per cycle while byte_stall is low; results leave one
// per cycle unless stalled, and a byte ending inner value spaces gives two.
// byte_stall rises only when the record queue is full.
// Reset empties the queue and clears the parser state and result_valid.
module http_request_head_parser_core #(
  parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] role,
  output logic       field_start,
  output logic       method_done,
  output logic       uri_done,
  output logic       version_done,
  output logic       header_done,
  output logic       request_done,
  output logic [2:0] error_code,
  output logic [3:0] version_major,
  output logic [3:0] version_minor,
  output logic       last
);
  import hrp_pkg::*;

  hrp_rec_t rec;
  hrp_rec_t head;
  logic     full;
  logic     empty;
  logic     pop;
  logic     push;

  assign byte_stall = full;
  assign push       = byte_valid && !full;

  hrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push_ok   (!full),
    .take      (byte_valid),
    .data_byte (data_byte),
    .restart   (restart),
    .rec       (rec)
  );

  hrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  hrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .role          (role),
    .field_start   (field_start),
    .method_done   (method_done),
    .uri_done      (uri_done),
    .version_done  (version_done),
    .header_done   (header_done),
    .request_done  (request_done),
    .error_code    (error_code),
    .version_major (version_major),
    .version_minor (version_minor),
    .last          (last)
  );

endmodule

>>> tb/sv/http_request_head_parser_core_test_pkg.sv
// Scoreboard for the HTTP request head parser test. It predicts the results of
// every accepted input word and checks the block's results against them in order.
// Depends on hrp_pkg for roles, error codes and character constants.
package http_request_head_parser_core_test_pkg;
  import hrp_pkg::*;

  typedef enum logic [4:0] {
    PS_START, PS_METHOD, PS_URI_GAP, PS_PATH, PS_VER_GAP, PS_H, PS_HT, PS_HTT, PS_HTTP,
    PS_MAJOR, PS_DOT, PS_MINOR, PS_LINE_END, PS_LINE_LF, PS_NAME_START, PS_NAME,
    PS_COLON, PS_VALUE_LEAD, PS_VALUE, PS_VALUE_GAP, PS_HDR_LF, PS_END_LF
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] role;
    logic       field_start;
    logic       method_done;
    logic       uri_done;
    logic       version_done;
    logic       header_done;
    logic       request_done;
    logic [2:0] error_code;
    logic [3:0] version_major;
    logic [3:0] version_minor;
    logic       last;
  } parse_result_t;

  class parse_scoreboard;
    parse_state_t  state;
    logic [1:0]    get_pos;
    logic [3:0]    major_digit;
    logic [3:0]    minor_digit;
    logic [2:0]    held_error;
    parse_result_t expected_results[$];
    int            mismatches;

    function new();
      mismatches = 0;
      restart_parse();
    endfunction

    function void restart_parse();
      state = PS_START;
      get_pos = 2'd0;
      major_digit = 4'd0;
      minor_digit = 4'd0;
      held_error = ERR_NONE;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_word(logic [7:0] c, logic restart_in);
      parse_result_t res;
      parse_result_t gap;
      logic          pair;
      logic [2:0]    fault;
      logic          digit;
      logic          path_ok;
      logic [7:0]    get_letter;
      if (restart_in) restart_parse();
      res = '0;
      gap = '0;
      pair = 1'b0;
      fault = ERR_NONE;
      digit = (c >= CH_0) && (c <= CH_9);
      path_ok = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || digit ||
                c == CH_UNDER || c == CH_SLASH || c == CH_DOT;
      get_letter = (get_pos == 2'd0) ? CH_G : (get_pos == 2'd1) ? CH_E : CH_T;
      if (held_error == ERR_NONE) begin
        case (state)
          PS_METHOD: begin
            if (get_pos < 2'd3 && c == get_letter) begin
              get_pos = get_pos + 2'd1;
            end else if (get_pos == 2'd3 && c == CH_SP) begin
              res.method_done = 1'b1;
              state = PS_URI_GAP;
            end else fault = ERR_METHOD;
          end
          PS_URI_GAP: begin
            if (c == CH_SLASH) begin
              res.out_byte = c;
              res.role = ROLE_URI;
              res.field_start = 1'b1;
              state = PS_PATH;
            end else if (c != CH_SP) fault = ERR_URI;
          end
          PS_PATH: begin
            if (c == CH_SP) begin
              res.uri_done = 1'b1;
              state = PS_VER_GAP;
            end else if (path_ok) begin
              res.out_byte = c;
              res.role = ROLE_URI;
            end else fault = ERR_URI;
          end
          PS_VER_GAP: begin
            if (c == CH_H) state = PS_H;
            else if (c != CH_SP) fault = ERR_CONSTANT;
          end
          PS_H: if (c == CH_T) state = PS_HT; else fault = ERR_CONSTANT;
          PS_HT: if (c == CH_T) state = PS_HTT; else fault = ERR_CONSTANT;
          PS_HTT: if (c == CH_P) state = PS_HTTP; else fault = ERR_CONSTANT;
          PS_HTTP: if (c == CH_SLASH) state = PS_MAJOR; else fault = ERR_CONSTANT;
          PS_MAJOR: begin
            if (digit) begin
              major_digit = c[3:0];
              state = PS_DOT;
            end else fault = ERR_VERSION;
          end
          PS_DOT: if (c == CH_DOT) state = PS_MINOR; else fault = ERR_VERSION;
          PS_MINOR: begin
            if (digit) begin
              minor_digit = c[3:0];
              res.version_done = 1'b1;
              state = PS_LINE_END;
            end else fault = ERR_VERSION;
          end
          PS_LINE_END: begin
            if (c == CH_CR) state = PS_LINE_LF;
            else if (c == CH_LF) state = PS_NAME_START;
            else fault = ERR_VERSION;
          end
          PS_LINE_LF: if (c == CH_LF) state = PS_NAME_START; else fault = ERR_LF;
          PS_NAME_START: begin
            if (c == CH_CR) begin
              state = PS_END_LF;
            end else if (c == CH_LF) begin
              res.request_done = 1'b1;
              state = PS_START;
            end else begin
              res.out_byte = c;
              res.role = ROLE_NAME;
              res.field_start = 1'b1;
              state = PS_NAME;
            end
          end
          PS_NAME: begin
            if (c == CH_COLON) state = PS_COLON;
            else if (c == CH_CR) state = PS_HDR_LF;
            else begin
              res.out_byte = c;
              res.role = ROLE_NAME;
            end
          end
          PS_COLON: if (c == CH_SP) state = PS_VALUE_LEAD; else fault = ERR_HEADER;
          PS_VALUE_LEAD: begin
            if (c == CH_CR) state = PS_HDR_LF;
            else if (c != CH_SP) begin
              res.out_byte = c;
              res.role = ROLE_VALUE;
              res.field_start = 1'b1;
              state = PS_VALUE;
            end
          end
          PS_VALUE: begin
            if (c == CH_CR) state = PS_HDR_LF;
            else if (c == CH_SP) state = PS_VALUE_GAP;
            else begin
              res.out_byte = c;
              res.role = ROLE_VALUE;
            end
          end
          PS_VALUE_GAP: begin
            if (c == CH_CR) state = PS_HDR_LF;
            else if (c != CH_SP) begin
              // A run of inner spaces comes out as one space ahead of this byte.
              pair = 1'b1;
              gap.out_byte = CH_SP;
              gap.role = ROLE_VALUE;
              gap.version_major = major_digit;
              gap.version_minor = minor_digit;
              res.out_byte = c;
              res.role = ROLE_VALUE;
              state = PS_VALUE;
            end
          end
          PS_HDR_LF: begin
            if (c == CH_LF) begin
              res.header_done = 1'b1;
              state = PS_NAME_START;
            end else fault = ERR_LF;
          end
          PS_END_LF: begin
            if (c == CH_LF) begin
              res.request_done = 1'b1;
              state = PS_START;
            end else fault = ERR_LF;
          end
          default: begin
            if (c == CH_G) begin
              get_pos = 2'd1;
              state = PS_METHOD;
            end else if (c != CH_CR && c != CH_LF) fault = ERR_METHOD;
          end
        endcase
        if (fault != ERR_NONE) held_error = fault;
      end
      res.error_code = held_error;
      res.version_major = major_digit;
      res.version_minor = minor_digit;
      res.last = 1'b1;
      if (pair) expected_results.push_back(gap);
      expected_results.push_back(res);
    endfunction

    function string describe(parse_result_t r);
      return $sformatf("byte %02h role %0d start %0b done m%0b u%0b v%0b h%0b r%0b %s",
                       r.out_byte, r.role, r.field_start, r.method_done, r.uri_done,
                       r.version_done, r.header_done, r.request_done,
                       $sformatf("err %0d ver %0d.%0d last %0b", r.error_code,
                                 r.version_major, r.version_minor, r.last));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result %s", describe(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          flag($sformatf("expected %s", describe(want)));
          if (mismatches <= 10) $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

>>> tb/sv/http_request_head_parser_core_test.sv
// Top level of the HTTP request head parser test: builds directed and random
// request streams, drives them with bursty input and stalled output, and checks.
// Depends on hrp_pkg, the test scoreboard package and the parser core.
module http_request_head_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;
  import http_request_head_parser_core_test_pkg::*;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_COIN, FLOW_RARE, FLOW_BEAT} flow_t;
  typedef enum logic [1:0] {FLAW_NONE, FLAW_BYTE, FLAW_CUT} flaw_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'd0;
  logic       restart = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] role;
  logic       field_start;
  logic       method_done;
  logic       uri_done;
  logic       version_done;
  logic       header_done;
  logic       request_done;
  logic [2:0] error_code;
  logic [3:0] version_major;
  logic [3:0] version_minor;
  logic       last;

  parse_scoreboard parse_sb;
  logic [8:0]      byte_stream[$];
  int              total_words;
  int              words_taken = 0;
  int              results_taken = 0;

  http_request_head_parser_core dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void add_text(string s, bit fresh);
    for (int i = 0; i < s.len(); i++) byte_stream.push_back({fresh && i == 0, s[i]});
  endfunction

  function automatic logic [7:0] path_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return CH_UNDER;
      4: return CH_SLASH;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF || c == CH_COLON);
    end else begin
      do c = 8'($urandom_range(33, 126)); while (c == CH_COLON);
    end
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_SP);
    end else c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  function automatic void add_request(bit fresh, flaw_t flaw);
    logic [7:0] req[$];
    int         words;
    int         cut;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) req.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    req.push_back(CH_G);
    req.push_back(CH_E);
    req.push_back(CH_T);
    repeat ($urandom_range(0, 3) == 0 ? 2 : 1) req.push_back(CH_SP);
    req.push_back(CH_SLASH);
    repeat ($urandom_range(0, 6)) req.push_back(path_char());
    repeat ($urandom_range(0, 3) == 0 ? 2 : 1) req.push_back(CH_SP);
    req.push_back(CH_H);
    req.push_back(CH_T);
    req.push_back(CH_T);
    req.push_back(CH_P);
    req.push_back(CH_SLASH);
    req.push_back(8'($urandom_range(8'h30, 8'h39)));
    req.push_back(CH_DOT);
    req.push_back(8'($urandom_range(8'h30, 8'h39)));
    if ($urandom_range(0, 2) != 0) req.push_back(CH_CR);
    req.push_back(CH_LF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) req.push_back(name_char());
      if ($urandom_range(0, 5) != 0) begin
        req.push_back(CH_COLON);
        repeat ($urandom_range(1, 3)) req.push_back(CH_SP);
        words = $urandom_range(0, 3);
        for (int w = 0; w < words; w++) begin
          if (w > 0) repeat ($urandom_range(1, 3)) req.push_back(CH_SP);
          repeat ($urandom_range(1, 4)) req.push_back(value_char());
        end
        repeat ($urandom_range(0, 2)) req.push_back(CH_SP);
      end
      req.push_back(CH_CR);
      req.push_back(CH_LF);
    end
    if ($urandom_range(0, 2) != 0) req.push_back(CH_CR);
    req.push_back(CH_LF);
    if (flaw == FLAW_BYTE) begin
      req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, req.size() - 1);
      while (req.size() > cut) void'(req.pop_back());
    end
    for (int i = 0; i < req.size(); i++) byte_stream.push_back({fresh && i == 0, req[i]});
  endfunction

  function automatic void build_directed();
    add_text({"\015\012GET  /azAZ09_/. HTTP/9.0\015\012Key:  a   b  \015\012",
              "NoColon\015\012Empty: \015\012\015\012"}, 1'b1);
    add_text("GET /  HTTP/1.1\012A: x\015\012\012", 1'b0);
    add_text("GEX Q", 1'b1);
    add_text("GET /a?b", 1'b1);
    add_text("GET / HTTX", 1'b1);
    add_text("GET / HTTP/x", 1'b1);
    add_text("GET / HTTP/1.1\015X", 1'b1);
    add_text("GET / HTTP/1.1\012A:x", 1'b1);
    add_text("GET /ab", 1'b1);
    add_text("GET / HTTP/2.3\015\012\015\012", 1'b1);
    byte_stream.push_back({1'b1, 8'hFF});
    byte_stream.push_back({1'b1, 8'h00});
  endfunction

  function automatic void build_random();
    bit dirty;
    int base;
    dirty = 1'b1;
    base = byte_stream.size();
    while (byte_stream.size() - base < 1500) begin
      case ($urandom_range(0, 11))
        0: begin
          repeat ($urandom_range(1, 8))
            byte_stream.push_back({$urandom_range(0, 3) == 0, 8'($urandom_range(0, 255))});
          dirty = 1'b1;
        end
        1: begin
          add_request(dirty || $urandom_range(0, 3) == 0, FLAW_BYTE);
          dirty = 1'b1;
        end
        2: begin
          add_request(dirty || $urandom_range(0, 3) == 0, FLAW_CUT);
          dirty = 1'b1;
        end
        default: begin
          add_request(dirty || $urandom_range(0, 5) == 0, FLAW_NONE);
          dirty = 1'b0;
        end
      endcase
    end
  endfunction

  task automatic drive_bytes();
    int         burst_left;
    int         gap_left;
    logic [8:0] word;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (byte_valid && !byte_stall) begin
          parse_sb.note_word(data_byte, restart);
          words_taken++;
        end
        if (!(byte_valid && byte_stall)) begin
          if (gap_left > 0) begin
            gap_left--;
            byte_valid <= 1'b0;
          end else if (byte_stream.size() > 0) begin
            word = byte_stream.pop_front();
            byte_valid <= 1'b1;
            restart <= word[8];
            data_byte <= word[7:0];
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 48);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end else byte_valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic drive_stall();
    flow_t mode;
    int    mode_left;
    int    hold_left;
    int    next_hold;
    int    beat;
    mode = FLOW_FREE;
    mode_left = 0;
    hold_left = 0;
    next_hold = 200;
    beat = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        parse_sb.check_result({out_byte, role, field_start, method_done, uri_done,
                               version_done, header_done, request_done, error_code,
                               version_major, version_minor, last});
        results_taken++;
      end
      if (results_taken >= next_hold) begin
        hold_left = 150;
        next_hold += 900;
      end
      if (mode_left == 0) begin
        mode = flow_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (mode)
          FLOW_FREE: result_stall <= 1'b0;
          FLOW_COIN: result_stall <= 1'($urandom_range(0, 1));
          FLOW_RARE: result_stall <= ($urandom_range(0, 7) == 0);
          default: result_stall <= (beat % 5) < 2;
        endcase
      end
    end
  endtask

  initial drive_bytes();
  initial drive_stall();

  initial begin
    parse_sb = new();
    build_directed();
    build_random();
    total_words = byte_stream.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (words_taken < total_words || parse_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (parse_sb.mismatches == 0 && parse_sb.pending() == 0) begin
      $display("http_request_head_parser_core_test passed");
    end else begin
      $display("http_request_head_parser_core_test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("http_request_head_parser_core_test failed");
    $finish;
  end

endmodule
